### design/arpc_pkg.sv
`default_nettype none

package arpc_pkg;

	// Received-packet field values that the block accepts.
	localparam logic [15:0] HW_ETHERNET = 16'h0001;
	localparam logic [15:0] PTYPE_IPV4  = 16'h0800;
	localparam logic [15:0] OP_REQUEST  = 16'd1;
	localparam logic [15:0] OP_REPLY    = 16'd2;

	// Operation codes on the transmit side.
	localparam logic [1:0] SEND_OP_NONE    = 2'd0;
	localparam logic [1:0] SEND_OP_REQUEST = 2'd1;
	localparam logic [1:0] SEND_OP_REPLY   = 2'd2;

	localparam logic [47:0] MAC_ALL_ONES = 48'hFFFF_FFFF_FFFF;

	// Input commands.
	localparam logic [1:0] CMD_RX      = 2'd0;
	localparam logic [1:0] CMD_LOOKUP  = 2'd1;
	localparam logic [1:0] CMD_RESOLVE = 2'd2;

	// Configuration register index of the device IP address.
	localparam logic REG_OWN_IP = 1'b0;

	typedef enum logic [2:0] {
		STATUS_OK         = 3'd0,
		STATUS_BAD_HW     = 3'd1,
		STATUS_BAD_PROTO  = 3'd2,
		STATUS_FULL       = 3'd3,
		STATUS_UNKNOWN_OP = 3'd4,
		STATUS_NOT_US     = 3'd5
	} arpc_status_t;

	// What the back end has to do with a queued beat.
	typedef enum logic [1:0] {
		KIND_STATUS  = 2'd0,
		KIND_RESOLVE = 2'd1,
		KIND_LOOKUP  = 2'd2,
		KIND_RX      = 2'd3
	} arpc_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_LAST = 2'd2,
		ST_DONE = 2'd3
	} arpc_state_t;

	typedef struct packed {
		arpc_kind_t   kind;
		arpc_status_t status;
		logic         op_req;
		logic         op_rep;
		logic         for_us;
		logic [31:0]  key_ip;
		logic [47:0]  mac;
	} arpc_item_t;

	typedef struct packed {
		logic         send_valid;
		logic [1:0]   send_opcode;
		logic [47:0]  send_link_mac;
		logic [47:0]  send_target_mac;
		logic [31:0]  send_target_ip;
		logic         lookup_hit;
		logic [47:0]  lookup_mac;
		arpc_status_t status;
	} arpc_result_t;

endpackage

`default_nettype wire

### design/arp_cache_responder.sv
// ARP cache and responder.
// Input channel: one beat carries a command (received ARP packet, cache lookup
// or resolve) with all packet and query fields; a beat is taken when in_valid
// is high and in_stall is low. Output channel: exactly one result beat per
// input beat, in input order, taken when out_valid is high and out_stall low.
// Configuration: cfg_we writes own_ip (index 0) or own_mac (index 1); the
// user must write only while the block is idle, which the block does not
// enforce. own_mac is in no result field, so it is not stored here; the
// transmit path fills in the sender address. A front end checks the header
// fields and decodes the command into a two-beat queue; the back end scans
// the cache, one entry per cycle through a registered-read memory, and
// updates it. Packets and lookups pass through the scan; resolves and
// rejected beats go straight to the result. The back end handles one beat
// at a time, while the queue can take further beats until it is full.
// Reset clears all entry valid bits at once, so no clearing pass is needed.
// A stalled receiver holds the result; the back end then waits with the next
// result and the queue fills, after which in_stall rises.
`default_nettype none

module arp_cache_responder #(
	parameter int CACHE_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [47:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] opcode,
	input  wire logic [15:0] hardware_type,
	input  wire logic [15:0] protocol_type,
	input  wire logic [47:0] sender_mac,
	input  wire logic [31:0] sender_ip,
	input  wire logic [31:0] target_ip,
	input  wire logic [31:0] query_ip,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             send_valid,
	output logic [1:0]       send_opcode,
	output logic [47:0]      send_link_mac,
	output logic [47:0]      send_target_mac,
	output logic [31:0]      send_target_ip,
	output logic             lookup_hit,
	output logic [47:0]      lookup_mac,
	output logic [2:0]       status
);

	logic [31:0]            own_ip_q;
	logic                   q_valid;
	logic                   q_pop;
	arpc_pkg::arpc_item_t   q_item;
	arpc_pkg::arpc_result_t result;

	// Device address; only the low 32 bits of the write data are kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= 32'd0;
		end else if (cfg_we && cfg_index == arpc_pkg::REG_OWN_IP) begin
			own_ip_q <= cfg_data[31:0];
		end
	end

	arpc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.own_ip        (own_ip_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.opcode        (opcode),
		.hardware_type (hardware_type),
		.protocol_type (protocol_type),
		.sender_mac    (sender_mac),
		.sender_ip     (sender_ip),
		.target_ip     (target_ip),
		.query_ip      (query_ip),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	arpc_back #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_result (result)
	);

	assign send_valid      = result.send_valid;
	assign send_opcode     = result.send_opcode;
	assign send_link_mac   = result.send_link_mac;
	assign send_target_mac = result.send_target_mac;
	assign send_target_ip  = result.send_target_ip;
	assign lookup_hit      = result.lookup_hit;
	assign lookup_mac      = result.lookup_mac;
	assign status          = result.status;

endmodule

`default_nettype wire

### design/arpc_ram.sv
`default_nettype none

module arpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### design/arpc_front.sv
`default_nettype none

module arpc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [31:0]        own_ip,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         command,
	input  wire logic [15:0]        opcode,
	input  wire logic [15:0]        hardware_type,
	input  wire logic [15:0]        protocol_type,
	input  wire logic [47:0]        sender_mac,
	input  wire logic [31:0]        sender_ip,
	input  wire logic [31:0]        target_ip,
	input  wire logic [31:0]        query_ip,
	output logic                    q_valid,
	output arpc_pkg::arpc_item_t    q_item,
	input  wire logic               q_pop
);

	arpc_pkg::arpc_item_t item;
	arpc_pkg::arpc_item_t entry_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 push;

	// Classification: header checks and command decode happen here, so the
	// back end only sees work that needs the cache or a ready-made answer.
	always_comb begin
		item        = '0;
		item.kind   = arpc_pkg::KIND_STATUS;
		item.status = arpc_pkg::STATUS_OK;
		case (command)
			arpc_pkg::CMD_RX: begin
				if (hardware_type != arpc_pkg::HW_ETHERNET) begin
					item.status = arpc_pkg::STATUS_BAD_HW;
				end else if (protocol_type != arpc_pkg::PTYPE_IPV4) begin
					item.status = arpc_pkg::STATUS_BAD_PROTO;
				end else begin
					item.kind   = arpc_pkg::KIND_RX;
					item.op_req = (opcode == arpc_pkg::OP_REQUEST);
					item.op_rep = (opcode == arpc_pkg::OP_REPLY);
					item.for_us = (target_ip == own_ip);
					item.key_ip = sender_ip;
					item.mac    = sender_mac;
				end
			end
			arpc_pkg::CMD_LOOKUP: begin
				item.kind   = arpc_pkg::KIND_LOOKUP;
				item.key_ip = query_ip;
			end
			arpc_pkg::CMD_RESOLVE: begin
				item.kind   = arpc_pkg::KIND_RESOLVE;
				item.key_ip = query_ip;
			end
			default: begin
				item.status = arpc_pkg::STATUS_UNKNOWN_OP;
			end
		endcase
	end

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

endmodule

`default_nettype wire

### design/arpc_back.sv
`default_nettype none

module arpc_back #(
	parameter int CACHE_ENTRIES = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  wire arpc_pkg::arpc_item_t  q_item,
	output logic                       q_pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output arpc_pkg::arpc_result_t     out_result
);

	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

	arpc_pkg::arpc_state_t  state_q;
	arpc_pkg::arpc_state_t  state_d;
	arpc_pkg::arpc_item_t   item_q;
	arpc_pkg::arpc_result_t res_d;
	arpc_pkg::arpc_result_t res_q;

	logic [CACHE_ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]         idx_q;
	logic [IDX_W-1:0]         idx_s1;
	logic                     rd_vld_s1;
	logic                     found_q;
	logic [IDX_W-1:0]         hit_idx_q;
	logic [47:0]              hit_mac_q;
	logic                     free_q;
	logic [IDX_W-1:0]         free_idx_q;
	logic                     out_valid_q;

	logic                     load;
	logic                     ip_we;
	logic                     mac_we;
	logic [IDX_W-1:0]         wr_idx;
	logic [31:0]              ip_rdata;
	logic [47:0]              mac_rdata;
	logic                     match;
	logic                     empty_slot;

	arpc_ram #(.WIDTH(32), .DEPTH(CACHE_ENTRIES)) u_ip_ram (
		.clk   (clk),
		.we    (ip_we),
		.waddr (wr_idx),
		.wdata (item_q.key_ip),
		.raddr (idx_q),
		.rdata (ip_rdata)
	);

	arpc_ram #(.WIDTH(48), .DEPTH(CACHE_ENTRIES)) u_mac_ram (
		.clk   (clk),
		.we    (mac_we),
		.waddr (wr_idx),
		.wdata (item_q.mac),
		.raddr (idx_q),
		.rdata (mac_rdata)
	);

	assign match      = rd_vld_s1 && valid_q[idx_s1] && (ip_rdata == item_q.key_ip);
	assign empty_slot = rd_vld_s1 && !valid_q[idx_s1];

	always_comb begin
		state_d = state_q;
		case (state_q)
			arpc_pkg::ST_IDLE: begin
				if (q_valid) begin
					if (q_item.kind == arpc_pkg::KIND_RX ||
					    q_item.kind == arpc_pkg::KIND_LOOKUP) begin
						state_d = arpc_pkg::ST_SCAN;
					end else begin
						state_d = arpc_pkg::ST_DONE;
					end
				end
			end
			arpc_pkg::ST_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_d = arpc_pkg::ST_LAST;
				end
			end
			arpc_pkg::ST_LAST: begin
				state_d = arpc_pkg::ST_DONE;
			end
			arpc_pkg::ST_DONE: begin
				if (load) begin
					state_d = arpc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = arpc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		q_pop  = (state_q == arpc_pkg::ST_IDLE) && q_valid;
		load   = (state_q == arpc_pkg::ST_DONE) && (!out_valid_q || !out_stall);
		res_d  = '0;
		res_d.status = arpc_pkg::STATUS_OK;
		ip_we  = 1'b0;
		mac_we = 1'b0;
		wr_idx = found_q ? hit_idx_q : free_idx_q;
		case (item_q.kind)
			arpc_pkg::KIND_STATUS: begin
				res_d.status = item_q.status;
			end
			arpc_pkg::KIND_RESOLVE: begin
				res_d.send_valid      = 1'b1;
				res_d.send_opcode     = arpc_pkg::SEND_OP_REQUEST;
				res_d.send_link_mac   = arpc_pkg::MAC_ALL_ONES;
				res_d.send_target_ip  = item_q.key_ip;
			end
			arpc_pkg::KIND_LOOKUP: begin
				res_d.lookup_hit = found_q;
				res_d.lookup_mac = found_q ? hit_mac_q : 48'd0;
			end
			arpc_pkg::KIND_RX: begin
				// A cached sender is refreshed whoever the packet was for.
				mac_we = load && (found_q || (item_q.for_us && free_q));
				ip_we  = load && !found_q && item_q.for_us && free_q;
				if (!item_q.for_us) begin
					res_d.status = arpc_pkg::STATUS_NOT_US;
				end else if (!found_q && !free_q) begin
					res_d.status = arpc_pkg::STATUS_FULL;
				end else if (item_q.op_req) begin
					res_d.send_valid      = 1'b1;
					res_d.send_opcode     = arpc_pkg::SEND_OP_REPLY;
					res_d.send_link_mac   = item_q.mac;
					res_d.send_target_mac = item_q.mac;
					res_d.send_target_ip  = item_q.key_ip;
				end else if (!item_q.op_rep) begin
					res_d.status = arpc_pkg::STATUS_UNKNOWN_OP;
				end
			end
			default: begin
				res_d.status = arpc_pkg::STATUS_UNKNOWN_OP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= arpc_pkg::ST_IDLE;
			valid_q     <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == arpc_pkg::ST_SCAN);
			if (q_pop) begin
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end else begin
				if (!found_q && match) begin
					found_q <= 1'b1;
				end
				if (!free_q && empty_slot) begin
					free_q <= 1'b1;
				end
			end
			if (ip_we) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (q_pop) begin
			item_q <= q_item;
			idx_q  <= '0;
		end else if (state_q == arpc_pkg::ST_SCAN) begin
			idx_q <= idx_q + 1'b1;
		end
		if (!found_q && match) begin
			hit_idx_q <= idx_s1;
			hit_mac_q <= mac_rdata;
		end
		if (!free_q && empty_slot) begin
			free_idx_q <= idx_s1;
		end
		if (load) begin
			res_q <= res_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = res_q;

	a_insert_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ip_we |-> !valid_q[wr_idx])
		else $error("insert into an occupied cache slot");

	a_insert_writes_mac: assert property (@(posedge clk) disable iff (!arst_n)
		ip_we |-> (mac_we && !found_q))
		else $error("insert without MAC write or despite a hit");

	a_last_compare: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == arpc_pkg::ST_LAST) |-> (rd_vld_s1 && idx_s1 == LAST_IDX))
		else $error("scan ended before the last entry was compared");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (out_valid_q && state_q == arpc_pkg::ST_IDLE))
		else $error("result load did not reach the output register");

endmodule

`default_nettype wire

### bench/arp_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port of the ARP engine. It keeps its
// own copy of the cache, predicts the result of every accepted input beat and
// compares each accepted result beat with the oldest prediction.
module arp_result_checker #(
	parameter int CACHE_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [47:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] opcode,
	input  wire logic [15:0] hardware_type,
	input  wire logic [15:0] protocol_type,
	input  wire logic [47:0] sender_mac,
	input  wire logic [31:0] sender_ip,
	input  wire logic [31:0] target_ip,
	input  wire logic [31:0] query_ip,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic        send_valid,
	input  wire logic [1:0]  send_opcode,
	input  wire logic [47:0] send_link_mac,
	input  wire logic [47:0] send_target_mac,
	input  wire logic [31:0] send_target_ip,
	input  wire logic        lookup_hit,
	input  wire logic [47:0] lookup_mac,
	input  wire logic [2:0]  status,
	output int               failures,
	output int               results_due
);
	import arpc_pkg::*;

	logic        cache_valid [CACHE_ENTRIES];
	logic [31:0] cache_ip    [CACHE_ENTRIES];
	logic [47:0] cache_mac   [CACHE_ENTRIES];
	logic [31:0] own_ip;

	arpc_result_t expected_results [$];
	arpc_result_t want;
	arpc_result_t got;
	string        wrong;

	// Lowest-numbered valid entry that holds the address, or -1.
	function automatic int cached_index(input logic [31:0] ip);
		for (int i = 0; i < CACHE_ENTRIES; i++) begin
			if (cache_valid[i] && cache_ip[i] == ip)
				return i;
		end
		return -1;
	endfunction

	// Works out the result of one beat and applies its effect on the cache.
	function automatic arpc_result_t arp_outcome(
		input logic [1:0]  cmd,
		input logic [15:0] op,
		input logic [15:0] hw,
		input logic [15:0] proto,
		input logic [47:0] s_mac,
		input logic [31:0] s_ip,
		input logic [31:0] t_ip,
		input logic [31:0] q_ip
	);
		arpc_result_t r;
		int           hit;
		int           slot;
		r = '0;
		r.status = STATUS_OK;
		case (cmd)
			CMD_RX: begin
				if (hw != HW_ETHERNET) begin
					r.status = STATUS_BAD_HW;
				end else if (proto != PTYPE_IPV4) begin
					r.status = STATUS_BAD_PROTO;
				end else begin
					hit = cached_index(s_ip);
					if (hit >= 0)
						cache_mac[hit] = s_mac;
					if (t_ip != own_ip) begin
						r.status = STATUS_NOT_US;
					end else begin
						slot = hit;
						if (hit < 0) begin
							for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
								if (!cache_valid[i])
									slot = i;
							end
							if (slot >= 0) begin
								cache_valid[slot] = 1'b1;
								cache_ip[slot] = s_ip;
								cache_mac[slot] = s_mac;
							end
						end
						if (slot < 0) begin
							r.status = STATUS_FULL;
						end else if (op == OP_REQUEST) begin
							r.send_valid = 1'b1;
							r.send_opcode = SEND_OP_REPLY;
							r.send_link_mac = s_mac;
							r.send_target_mac = s_mac;
							r.send_target_ip = s_ip;
						end else if (op != OP_REPLY) begin
							r.status = STATUS_UNKNOWN_OP;
						end
					end
				end
			end
			CMD_LOOKUP: begin
				hit = cached_index(q_ip);
				if (hit >= 0) begin
					r.lookup_hit = 1'b1;
					r.lookup_mac = cache_mac[hit];
				end
			end
			CMD_RESOLVE: begin
				r.send_valid = 1'b1;
				r.send_opcode = SEND_OP_REQUEST;
				r.send_link_mac = MAC_ALL_ONES;
				r.send_target_ip = q_ip;
			end
			default: begin
				r.status = STATUS_UNKNOWN_OP;
			end
		endcase
		return r;
	endfunction

	function automatic string describe(input arpc_result_t r);
		return $sformatf("send %b op %0d link %h tmac %h tip %h hit %b mac %h status %0d",
			r.send_valid, r.send_opcode, r.send_link_mac, r.send_target_mac,
			r.send_target_ip, r.lookup_hit, r.lookup_mac, r.status);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CACHE_ENTRIES; i++)
				cache_valid[i] = 1'b0;
			own_ip = '0;
			expected_results.delete();
			failures = 0;
			results_due <= 0;
		end else begin
			// The device MAC never shows up in a result, so only the address
			// register matters for prediction.
			if (cfg_we && cfg_index == REG_OWN_IP)
				own_ip = cfg_data[31:0];

			if (out_valid && !out_stall) begin
				got.send_valid = send_valid;
				got.send_opcode = send_opcode;
				got.send_link_mac = send_link_mac;
				got.send_target_mac = send_target_mac;
				got.send_target_ip = send_target_ip;
				got.lookup_hit = lookup_hit;
				got.lookup_mac = lookup_mac;
				got.status = arpc_status_t'(status);
				if (expected_results.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: result beat with nothing expected: %s",
							$time, describe(got));
				end else begin
					want = expected_results.pop_front();
					wrong = "";
					if (got.send_valid !== want.send_valid)
						wrong = {wrong, " send_valid"};
					if (got.send_opcode !== want.send_opcode)
						wrong = {wrong, " send_opcode"};
					if (got.send_link_mac !== want.send_link_mac)
						wrong = {wrong, " send_link_mac"};
					if (got.send_target_mac !== want.send_target_mac)
						wrong = {wrong, " send_target_mac"};
					if (got.send_target_ip !== want.send_target_ip)
						wrong = {wrong, " send_target_ip"};
					if (got.lookup_hit !== want.lookup_hit)
						wrong = {wrong, " lookup_hit"};
					if (got.lookup_mac !== want.lookup_mac)
						wrong = {wrong, " lookup_mac"};
					if (got.status !== want.status)
						wrong = {wrong, " status"};
					if (wrong != "") begin
						failures++;
						if (failures <= 10) begin
							$display("%0t: mismatch in%s", $time, wrong);
							$display("  expected %s", describe(want));
							$display("  actual   %s", describe(got));
						end
					end
				end
			end

			if (in_valid && !in_stall)
				expected_results.push_back(arp_outcome(command, opcode, hardware_type,
					protocol_type, sender_mac, sender_ip, target_ip, query_ip));

			results_due <= expected_results.size();
		end
	end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

// Top of the ARP engine bench. This module only makes stimulus and gives the
// verdict; all prediction and comparison live in the checker instance.
module tb_top;
	import arpc_pkg::*;

	localparam int CACHE_ENTRIES = 16;
	// Settling time after the last result, sized from the cache depth with margin on top.
	localparam int SETTLE_CYCLES = CACHE_ENTRIES + 8;
	// Senders are drawn from a pool somewhat larger than the cache, so the
	// cache fills up, later packets hit or refresh, and some find it full.
	localparam int IP_POOL_SIZE = 24;
	localparam logic REG_OWN_MAC = 1'b1;
	// The command encoding leaves one value unused; the block must flag it.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] opcode;
		logic [15:0] hardware_type;
		logic [15:0] protocol_type;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [31:0] target_ip;
		logic [31:0] query_ip;
	} arp_beat_t;

	// Every input of the block starts at a known value.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [47:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        out_stall = 1'b0;
	logic [1:0]  command = '0;
	logic [15:0] opcode = '0;
	logic [15:0] hardware_type = '0;
	logic [15:0] protocol_type = '0;
	logic [47:0] sender_mac = '0;
	logic [31:0] sender_ip = '0;
	logic [31:0] target_ip = '0;
	logic [31:0] query_ip = '0;

	logic        in_stall;
	logic        out_valid;
	logic        send_valid;
	logic [1:0]  send_opcode;
	logic [47:0] send_link_mac;
	logic [47:0] send_target_mac;
	logic [31:0] send_target_ip;
	logic        lookup_hit;
	logic [47:0] lookup_mac;
	logic [2:0]  status;

	// Chance in percent that the sender holds back a cycle, and that the
	// receiver stalls a cycle.
	int send_idle_pct = 17;
	int recv_idle_pct = 86;

	logic [31:0] ip_pool [IP_POOL_SIZE];
	logic [31:0] own_ip_now = '0;
	int          fail_count;
	int          results_due;
	int          packets_sent = 0;
	int          lookups_sent = 0;
	int          resolves_sent = 0;
	int          unused_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	arp_cache_responder #(
		.CACHE_ENTRIES(CACHE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.opcode(opcode),
		.hardware_type(hardware_type),
		.protocol_type(protocol_type),
		.sender_mac(sender_mac),
		.sender_ip(sender_ip),
		.target_ip(target_ip),
		.query_ip(query_ip),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.send_valid(send_valid),
		.send_opcode(send_opcode),
		.send_link_mac(send_link_mac),
		.send_target_mac(send_target_mac),
		.send_target_ip(send_target_ip),
		.lookup_hit(lookup_hit),
		.lookup_mac(lookup_mac),
		.status(status)
	);

	arp_result_checker #(
		.CACHE_ENTRIES(CACHE_ENTRIES)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.opcode(opcode),
		.hardware_type(hardware_type),
		.protocol_type(protocol_type),
		.sender_mac(sender_mac),
		.sender_ip(sender_ip),
		.target_ip(target_ip),
		.query_ip(query_ip),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.send_valid(send_valid),
		.send_opcode(send_opcode),
		.send_link_mac(send_link_mac),
		.send_target_mac(send_target_mac),
		.send_target_ip(send_target_ip),
		.lookup_hit(lookup_hit),
		.lookup_mac(lookup_mac),
		.status(status),
		.failures(fail_count),
		.results_due(results_due)
	);

	// The receiver decides afresh every cycle whether to stall. Stalls that
	// land while no result is offered are harmless and keep the pattern simple.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	function automatic logic [15:0] any_half();
		logic [31:0] r;
		r = $urandom;
		return r[15:0];
	endfunction

	function automatic logic [47:0] any_mac();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[47:0];
	endfunction

	function automatic logic [31:0] pool_ip();
		return ip_pool[$urandom_range(0, IP_POOL_SIZE - 1)];
	endfunction

	// A received packet beat; the query field is unused and left at zero.
	function automatic arp_beat_t rx_beat(
		input logic [15:0] op,
		input logic [15:0] hw,
		input logic [15:0] proto,
		input logic [47:0] s_mac,
		input logic [31:0] s_ip,
		input logic [31:0] t_ip
	);
		arp_beat_t b;
		b = '0;
		b.command = CMD_RX;
		b.opcode = op;
		b.hardware_type = hw;
		b.protocol_type = proto;
		b.sender_mac = s_mac;
		b.sender_ip = s_ip;
		b.target_ip = t_ip;
		return b;
	endfunction

	// A lookup or resolve beat with the packet fields at zero.
	function automatic arp_beat_t query_beat(input logic [1:0] cmd, input logic [31:0] q_ip);
		arp_beat_t b;
		b = '0;
		b.command = cmd;
		b.query_ip = q_ip;
		return b;
	endfunction

	// Random traffic. Almost half the beats are well-formed packets from the
	// address pool aimed at this device, so they get past the header checks and
	// work the cache: insertion, refresh, reply and the full case. The fields
	// that a command ignores are still random so that every input bit toggles.
	function automatic arp_beat_t random_beat();
		arp_beat_t   b;
		int          pick;
		int          mix;
		logic [31:0] r;
		b.command = CMD_RX;
		b.opcode = any_half();
		b.hardware_type = any_half();
		b.protocol_type = any_half();
		b.sender_mac = any_mac();
		b.sender_ip = $urandom;
		b.target_ip = $urandom;
		b.query_ip = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			b.hardware_type = HW_ETHERNET;
			b.protocol_type = PTYPE_IPV4;
			mix = $urandom_range(0, 9);
			if (mix < 4)
				b.opcode = OP_REQUEST;
			else if (mix < 8)
				b.opcode = OP_REPLY;
			if ($urandom_range(0, 9) != 0)
				b.sender_ip = pool_ip();
			if ($urandom_range(0, 4) != 0)
				b.target_ip = own_ip_now;
		end else if (pick < 65) begin
			b.command = CMD_LOOKUP;
			if ($urandom_range(0, 4) != 0)
				b.query_ip = pool_ip();
		end else if (pick < 75) begin
			b.command = CMD_RESOLVE;
		end else if (pick < 90) begin
			// Broken header on an otherwise useful packet: it must not touch
			// the cache even though sender and target would qualify.
			b.sender_ip = pool_ip();
			b.target_ip = own_ip_now;
			if ($urandom_range(0, 1) != 0)
				b.hardware_type = HW_ETHERNET;
		end else if (pick < 95) begin
			b.command = CMD_UNUSED;
		end else begin
			r = $urandom;
			b.command = r[1:0];
		end
		return b;
	endfunction

	// Offers one beat and returns at the edge where it is taken. The sender
	// may first hold back with valid low; valid is only ever assigned once
	// per edge, so a back-to-back beat keeps valid high without a glitch.
	task automatic send_beat(input arp_beat_t b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= b.command;
		opcode <= b.opcode;
		hardware_type <= b.hardware_type;
		protocol_type <= b.protocol_type;
		sender_mac <= b.sender_mac;
		sender_ip <= b.sender_ip;
		target_ip <= b.target_ip;
		query_ip <= b.query_ip;
		case (b.command)
			CMD_RX:      packets_sent++;
			CMD_LOOKUP:  lookups_sent++;
			CMD_RESOLVE: resolves_sent++;
			default:     unused_sent++;
		endcase
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++)
			send_beat(random_beat());
	endtask

	// Stops sending, waits until every predicted result has been taken, then
	// gives the back end time to finish any cache write of the last beat.
	// The checker's count is registered, hence the edge before the first look.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both address registers; only called while the block is idle.
	task automatic set_addresses(input logic [31:0] ip, input logic [47:0] mac);
		cfg_we <= 1'b1;
		cfg_index <= REG_OWN_IP;
		cfg_data <= {16'h0000, ip};
		@(posedge clk);
		cfg_index <= REG_OWN_MAC;
		cfg_data <= mac;
		@(posedge clk);
		cfg_we <= 1'b0;
		own_ip_now = ip;
	endtask

	initial begin
		for (int i = 0; i < IP_POOL_SIZE; i++)
			ip_pool[i] = $urandom;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the device address at all ones and the device
		// MAC at zero. The cache starts empty, so the first lookup must miss.
		set_addresses(32'hFFFF_FFFF, 48'h0);
		send_beat(query_beat(CMD_LOOKUP, 32'h0));
		// A request for us from an unknown sender inserts it and is answered.
		send_beat(rx_beat(OP_REQUEST, HW_ETHERNET, PTYPE_IPV4, any_mac(), ip_pool[0],
			own_ip_now));
		send_beat(query_beat(CMD_LOOKUP, ip_pool[0]));
		// A reply is cached but not answered.
		send_beat(rx_beat(OP_REPLY, HW_ETHERNET, PTYPE_IPV4, any_mac(), ip_pool[1],
			own_ip_now));
		// Unknown opcodes still update the cache but report an unknown operation.
		send_beat(rx_beat(16'hFFFF, HW_ETHERNET, PTYPE_IPV4, any_mac(), ip_pool[2],
			own_ip_now));
		send_beat(rx_beat(16'h0000, HW_ETHERNET, PTYPE_IPV4, 48'h0, ip_pool[3],
			own_ip_now));
		send_beat(rx_beat(OP_REQUEST, HW_ETHERNET, PTYPE_IPV4, '1, ip_pool[4],
			own_ip_now));
		// A cached sender is refreshed in place, not inserted a second time.
		send_beat(rx_beat(OP_REQUEST, HW_ETHERNET, PTYPE_IPV4, any_mac(), ip_pool[0],
			own_ip_now));
		// Header checks: an all-zero beat, both fields wrong (hardware type
		// wins), then only the protocol wrong.
		send_beat(rx_beat(16'h0000, 16'h0000, 16'h0000, 48'h0, 32'h0, 32'h0));
		send_beat(rx_beat(OP_REQUEST, 16'hFFFF, 16'h0000, any_mac(), ip_pool[5],
			own_ip_now));
		send_beat(rx_beat(OP_REQUEST, HW_ETHERNET, 16'hFFFF, any_mac(), ip_pool[5],
			own_ip_now));
		// Not addressed to us: a cached sender still gets its MAC refreshed,
		// an unknown one is not inserted.
		send_beat(rx_beat(OP_REPLY, HW_ETHERNET, PTYPE_IPV4, any_mac(), ip_pool[1], 32'h0));
		send_beat(query_beat(CMD_LOOKUP, ip_pool[1]));
		send_beat(rx_beat(OP_REQUEST, HW_ETHERNET, PTYPE_IPV4, any_mac(), ip_pool[5],
			32'h0));
		send_beat(query_beat(CMD_LOOKUP, ip_pool[5]));
		send_beat(query_beat(CMD_RESOLVE, 32'hFFFF_FFFF));
		send_beat(query_beat(CMD_RESOLVE, 32'h0));
		// All ones everywhere, which is also the unused command value.
		send_beat('1);
		send_beat(rx_beat(OP_REQUEST, HW_ETHERNET, PTYPE_IPV4, any_mac(), 32'h0,
			own_ip_now));
		send_beat(rx_beat(OP_REPLY, HW_ETHERNET, PTYPE_IPV4, any_mac(), 32'hFFFF_FFFF,
			own_ip_now));
		send_beat(query_beat(CMD_LOOKUP, 32'hFFFF_FFFF));
		drain();

		// Random part in three phases. Each one has its own address setting
		// and its own flow-control mix: a mostly stalled receiver first, then
		// a mostly idle sender, then full rate on both sides.
		set_addresses($urandom, any_mac());
		run_random(700);
		drain();

		send_idle_pct <= 86;
		recv_idle_pct <= 17;
		set_addresses(32'h0, '1);
		run_random(700);
		drain();

		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		set_addresses($urandom, any_mac());
		run_random(600);
		drain();

		$display("Sent %0d packets, %0d lookups, %0d resolves and %0d unused commands",
			packets_sent, lookups_sent, resolves_sent, unused_sent);
		$display("under four address settings and three stall mixes; %0d failures seen.",
			fail_count);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog: a normal run needs well under a tenth of this.
	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
